// ----- sv/tpr_pkg.sv -----
`default_nettype none

package tpr_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned ID_W       = 16;
    localparam int unsigned VAL_W      = 32;
    localparam int unsigned POLL_W     = 112;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned FIFO_DEPTH = 2;
    localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [BYTE_W-1:0] RST_HEADER_BYTE      = 8'h7E;
    localparam logic [BYTE_W-1:0] RST_FRAME_TYPE       = 8'h10;
    localparam logic [BYTE_W-1:0] RST_ALTITUDE_POLL_ID = 8'h00;
    localparam logic [BYTE_W-1:0] RST_BATTERY_POLL_ID  = 8'h22;
    localparam logic [ID_W-1:0]   RST_ALTITUDE_DATA_ID = 16'h0100;
    localparam logic [ID_W-1:0]   RST_CURRENT_DATA_ID  = 16'h0200;
    localparam logic [ID_W-1:0]   RST_VOLTAGE_DATA_ID  = 16'h0210;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER_BYTE      = 3'd0,
        CFG_FRAME_TYPE       = 3'd1,
        CFG_ALTITUDE_POLL_ID = 3'd2,
        CFG_BATTERY_POLL_ID  = 3'd3,
        CFG_ALTITUDE_DATA_ID = 3'd4,
        CFG_CURRENT_DATA_ID  = 3'd5,
        CFG_VOLTAGE_DATA_ID  = 3'd6
    } cfg_index_t;

    // poll_header sits in the lowest bits
    typedef struct packed {
        logic signed [VAL_W-1:0]  voltage_cv;
        logic signed [VAL_W-1:0]  current_da;
        logic signed [VAL_W-1:0]  altitude_cm;
        logic        [BYTE_W-1:0] poll_id;
        logic        [BYTE_W-1:0] poll_header;
    } poll_t;

    // seven unescaped answer bytes, first line byte in the lowest bits
    typedef struct packed {
        logic [VAL_W-1:0]  value;
        logic [ID_W-1:0]   data_id;
        logic [BYTE_W-1:0] frame_type;
    } frame_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_BYTE,
        BK_ESC
    } back_state_t;

endpackage

`default_nettype wire

// ----- sv/tpr_front.sv -----
`default_nettype none

module tpr_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [tpr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tpr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire tpr_pkg::poll_t                 poll,
    input  wire tpr_pkg::fifo_status_t          fifo_stat,
    output logic                                push,
    output tpr_pkg::frame_t                     push_frame
);
    import tpr_pkg::*;

    logic [BYTE_W-1:0] header_byte_reg;
    logic [BYTE_W-1:0] frame_type_reg;
    logic [BYTE_W-1:0] altitude_poll_id_reg;
    logic [BYTE_W-1:0] battery_poll_id_reg;
    logic [ID_W-1:0]   altitude_data_id_reg;
    logic [ID_W-1:0]   current_data_id_reg;
    logic [ID_W-1:0]   voltage_data_id_reg;
    logic              battery_phase_reg;
    logic              battery_phase_next;

    logic accept;
    logic hdr_ok;
    logic is_alt;
    logic is_bat;

    assign s_tready = !fifo_stat.full;
    assign accept   = s_tvalid && s_tready;

    assign hdr_ok = (poll.poll_header == header_byte_reg);
    assign is_alt = hdr_ok && (poll.poll_id == altitude_poll_id_reg);
    // altitude wins when both ids are equal
    assign is_bat = hdr_ok && !is_alt && (poll.poll_id == battery_poll_id_reg);

    assign push = accept && (is_alt || is_bat);

    always_comb
    begin
        push_frame.frame_type = frame_type_reg;
        if (is_alt)
        begin
            push_frame.data_id = altitude_data_id_reg;
            push_frame.value   = poll.altitude_cm;
        end
        else if (!battery_phase_reg)
        begin
            push_frame.data_id = current_data_id_reg;
            push_frame.value   = poll.current_da;
        end
        else
        begin
            push_frame.data_id = voltage_data_id_reg;
            push_frame.value   = poll.voltage_cv;
        end
    end

    assign battery_phase_next = (accept && is_bat) ? !battery_phase_reg : battery_phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_byte_reg      <= RST_HEADER_BYTE;
            frame_type_reg       <= RST_FRAME_TYPE;
            altitude_poll_id_reg <= RST_ALTITUDE_POLL_ID;
            battery_poll_id_reg  <= RST_BATTERY_POLL_ID;
            altitude_data_id_reg <= RST_ALTITUDE_DATA_ID;
            current_data_id_reg  <= RST_CURRENT_DATA_ID;
            voltage_data_id_reg  <= RST_VOLTAGE_DATA_ID;
            battery_phase_reg    <= 1'b0;
        end
        else
        begin
            battery_phase_reg <= battery_phase_next;
            if (cfg_wr_en)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_HEADER_BYTE:      header_byte_reg      <= cfg_data[BYTE_W-1:0];
                    CFG_FRAME_TYPE:       frame_type_reg       <= cfg_data[BYTE_W-1:0];
                    CFG_ALTITUDE_POLL_ID: altitude_poll_id_reg <= cfg_data[BYTE_W-1:0];
                    CFG_BATTERY_POLL_ID:  battery_poll_id_reg  <= cfg_data[BYTE_W-1:0];
                    CFG_ALTITUDE_DATA_ID: altitude_data_id_reg <= cfg_data[ID_W-1:0];
                    CFG_CURRENT_DATA_ID:  current_data_id_reg  <= cfg_data[ID_W-1:0];
                    CFG_VOLTAGE_DATA_ID:  voltage_data_id_reg  <= cfg_data[ID_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/tpr_fifo.sv -----
`default_nettype none

module tpr_fifo (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire tpr_pkg::frame_t       push_frame,
    input  wire logic                  pop,
    output tpr_pkg::frame_t            pop_frame,
    output tpr_pkg::fifo_status_t      stat
);
    import tpr_pkg::*;

    frame_t                 entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]  count_reg;
    logic [FIFO_CNT_W-1:0]  count_next;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign pop_frame  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_frame;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && stat.full))
        else $error("request pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && stat.empty))
        else $error("request popped from empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("queue count past depth");
`endif

endmodule

`default_nettype wire

// ----- sv/tpr_back.sv -----
`default_nettype none

module tpr_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire tpr_pkg::fifo_status_t      fifo_stat,
    output logic                            pop,
    input  wire tpr_pkg::frame_t            pop_frame,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [tpr_pkg::BYTE_W-1:0]      m_tdata,
    output logic                            m_tlast
);
    import tpr_pkg::*;

    localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'h7D;
    localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7E;
    localparam logic [BYTE_W-1:0] ESC_XOR   = 8'h20;
    localparam logic [BYTE_W-1:0] CHK_BASE  = 8'hFF;
    localparam logic [2:0]        LAST_IDX  = 3'd7;

    back_state_t        state_reg;
    back_state_t        state_next;
    frame_t             frame_reg;
    logic [2:0]         idx_reg;
    logic [BYTE_W-1:0]  sum_reg;
    logic [BYTE_W-1:0]  sum_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [BYTE_W-1:0]  out_byte_reg;
    logic               out_last_reg;

    logic [7:0][BYTE_W-1:0] line;
    logic [BYTE_W-1:0]  cur;
    logic               cur_esc;
    logic               is_last;
    logic               out_free;
    logic [BYTE_W:0]    sum_wide;
    logic [BYTE_W:0]    sum_fold;

    logic               load;
    logic               emit;
    logic               advance;
    logic [BYTE_W-1:0]  emit_byte;
    logic               emit_last;

    // check byte rides as the eighth line byte
    assign line     = {CHK_BASE - sum_reg, frame_reg};
    assign cur      = line[idx_reg];
    assign cur_esc  = (cur == ESC_BYTE) || (cur == FLAG_BYTE);
    assign is_last  = (idx_reg == LAST_IDX);
    assign out_free = !out_valid_reg || m_tready;

    // ones' complement style fold of the carry back into the low byte
    assign sum_wide = {1'b0, sum_reg} + {1'b0, cur};
    assign sum_fold = sum_wide + {{BYTE_W{1'b0}}, sum_wide[BYTE_W]};
    assign sum_next = sum_fold[BYTE_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!fifo_stat.empty)
                begin
                    state_next = BK_BYTE;
                end
            end
            BK_BYTE:
            begin
                if (out_free)
                begin
                    if (cur_esc)
                    begin
                        state_next = BK_ESC;
                    end
                    else if (is_last)
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            BK_ESC:
            begin
                if (out_free)
                begin
                    state_next = is_last ? BK_IDLE : BK_BYTE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        pop       = 1'b0;
        load      = 1'b0;
        emit      = 1'b0;
        advance   = 1'b0;
        emit_byte = cur;
        emit_last = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!fifo_stat.empty)
                begin
                    pop  = 1'b1;
                    load = 1'b1;
                end
            end
            BK_BYTE:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (cur_esc)
                    begin
                        emit_byte = ESC_BYTE;
                    end
                    else
                    begin
                        emit_last = is_last;
                        advance   = 1'b1;
                    end
                end
            end
            BK_ESC:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    emit_byte = cur ^ ESC_XOR;
                    emit_last = is_last;
                    advance   = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign out_valid_next = emit ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (load)
            begin
                idx_reg <= '0;
            end
            else if (advance)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            frame_reg <= pop_frame;
            sum_reg   <= '0;
        end
        else if (advance)
        begin
            sum_reg <= sum_next;
        end
        if (emit)
        begin
            out_byte_reg <= emit_byte;
            out_last_reg <= emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_esc_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_ESC) |-> (out_valid_reg && (out_byte_reg == ESC_BYTE)))
        else $error("escape state without escape byte in output register");

    a_no_flag_out: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid_reg && (out_byte_reg == FLAG_BYTE)))
        else $error("unescaped flag byte on line");

    a_last_not_esc: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> (out_byte_reg != ESC_BYTE))
        else $error("frame ends on escape byte");
`endif

endmodule

`default_nettype wire

// ----- sv/telemetry_poll_responder.sv -----
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata: one poll request with telemetry values
// m_*       out  m_tvalid/m_tready  m_tdata: one line byte, m_tlast on check byte
// cfg_*     in   cfg_wr_en          cfg_index, cfg_data: register write
//
// A poll request is taken whenever the two-entry queue has room.
// The serializer pops a request, then sends one line byte per cycle while m_tready allows:
// 8 to 16 bytes per answered poll; ignored polls are not queued.
// The output register lets the serializer stall on m_tready without losing bytes.
// Reset (rst_n, async, active low) restores the register defaults and battery phase 0.
`default_nettype none

module telemetry_poll_responder (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [tpr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tpr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // poll_header[7:0], poll_id[15:8], altitude_cm[47:16], current_da[79:48],
    // voltage_cv[111:80]
    input  wire logic [tpr_pkg::POLL_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // tx_byte[7:0]
    output logic [tpr_pkg::BYTE_W-1:0]          m_tdata,
    output logic                                m_tlast
);
    import tpr_pkg::*;

    poll_t        poll;
    fifo_status_t fifo_stat;
    logic         push;
    frame_t       push_frame;
    logic         pop;
    frame_t       pop_frame;

    assign poll = poll_t'(s_tdata);

    tpr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .poll       (poll),
        .fifo_stat  (fifo_stat),
        .push       (push),
        .push_frame (push_frame)
    );

    tpr_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .pop        (pop),
        .pop_frame  (pop_frame),
        .stat       (fifo_stat)
    );

    tpr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_stat  (fifo_stat),
        .pop        (pop),
        .pop_frame  (pop_frame),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire
